/* hdl/rtua_pkg.sv */
// ----------------------------------------------------------------------------
// Route table package
// Shared types and constants of the route table with route aging.
// ----------------------------------------------------------------------------
`default_nettype none

package rtua_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
  localparam logic [15:0] DEACTIVATE_RESET = 16'd180;
  localparam logic [4:0] METRIC_INF = 5'd16;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SEL_HOP    = 2'd0,
    SEL_PORT   = 2'd1,
    SEL_ADDR   = 2'd2,
    SEL_METRIC = 2'd3
  } sel_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] hop;
    logic [15:0] port;
    logic [15:0] addr;
    logic [4:0]  metric;
    sel_t        sel;
    logic        hit;
    logic        created;
    logic [15:0] value;
  } link_t;

endpackage

`default_nettype wire

/* hdl/route_table_update_and_aging.sv */
// ----------------------------------------------------------------------------
// Route table update and aging
// Distance-vector route table keyed by next hop, with per-route aging.
//
//   channel   direction  handshake            payload
//   command   in         start, busy          action, hop_id, out_port,
//                                             dest_addr, route_metric,
//                                             field_select
//   result    out        done                 found, field_value,
//                                             table_full, entry_count
//   config    in         cfg_we               cfg_wdata (deactivate_time)
//
// A command is registered at the input, walks the row of cells, one cell per
// cycle, and its result is registered at the output; busy stays high until the
// result is registered. The result is on the ports for one cycle with done.
// Reset clears all route valid bits at once and sets deactivate_time to 180.
// The receiver cannot stall; commands wait only on busy.
// ----------------------------------------------------------------------------
`default_nettype none

module route_table_update_and_aging #(
  parameter int unsigned TABLE_DEPTH = rtua_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] hop_id,
  input  wire logic [15:0] out_port,
  input  wire logic [15:0] dest_addr,
  input  wire logic [4:0]  route_metric,
  input  wire logic [1:0]  field_select,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             done,
  output logic             found,
  output logic [15:0]      field_value,
  output logic             table_full,
  output logic [4:0]       entry_count
);

  localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EXT_W = (COUNT_W > 5) ? COUNT_W : 5;
  localparam logic [4:0] FULL_COUNT =
    (TABLE_DEPTH > 31) ? rtua_pkg::COUNT_MAX : 5'(TABLE_DEPTH);

  logic [15:0]         deactivate_time;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [EXT_W-1:0]    count_ext;
  logic                accept;
  rtua_pkg::link_t     tail;

  logic                link_valid [TABLE_DEPTH+1];
  rtua_pkg::link_t     link       [TABLE_DEPTH+1];

  assign accept = start && !busy;
  assign tail   = link[TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      deactivate_time <= rtua_pkg::DEACTIVATE_RESET;
    end else if (cfg_we) begin
      deactivate_time <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid[0] <= 1'b0;
    end else begin
      link_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      link[0].action  <= rtua_pkg::action_t'(action);
      link[0].hop     <= hop_id;
      link[0].port    <= out_port;
      link[0].addr    <= dest_addr;
      link[0].metric  <= route_metric;
      link[0].sel     <= rtua_pkg::sel_t'(field_select);
      link[0].hit     <= 1'b0;
      link[0].created <= 1'b0;
      link[0].value   <= '0;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rtua_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .deactivate_time (deactivate_time),
      .in_valid        (link_valid[i]),
      .in_link         (link[i]),
      .out_valid       (link_valid[i+1]),
      .out_link        (link[i+1])
    );
  end

  assign count_next = count + COUNT_W'(tail.created);
  assign count_ext  = EXT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= link_valid[TABLE_DEPTH];
      if (accept) begin
        busy <= 1'b1;
      end else if (link_valid[TABLE_DEPTH]) begin
        busy <= 1'b0;
      end
      if (link_valid[TABLE_DEPTH]) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_valid[TABLE_DEPTH]) begin
      found       <= (tail.action == rtua_pkg::ACT_LOOKUP) && tail.hit;
      field_value <= tail.value;
      table_full  <= (tail.action == rtua_pkg::ACT_UPDATE) && !tail.hit;
      entry_count <= (count_ext > EXT_W'(rtua_pkg::COUNT_MAX)) ?
                     rtua_pkg::COUNT_MAX : count_ext[4:0];
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (entry_count == FULL_COUNT))
    else $error("update dropped while the table had room");

  a_found_not_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && table_full))
    else $error("lookup hit and dropped update in one result");
`endif

endmodule

`default_nettype wire

/* hdl/rtua_cell.sv */
// ----------------------------------------------------------------------------
// Route table cell
// Holds one route, applies the passing command to it and forwards the command.
// ----------------------------------------------------------------------------
`default_nettype none

module rtua_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [15:0]    deactivate_time,
  input  wire logic           in_valid,
  input  wire rtua_pkg::link_t in_link,
  output logic                out_valid,
  output rtua_pkg::link_t     out_link
);

  logic        valid;
  logic [15:0] hop;
  logic [15:0] port;
  logic [15:0] addr;
  logic [4:0]  metric;
  logic        inactive;
  logic [15:0] active_ticks;
  logic [15:0] garbage_ticks;

  logic        valid_next;
  logic [15:0] hop_next;
  logic [15:0] port_next;
  logic [15:0] addr_next;
  logic [4:0]  metric_next;
  logic        inactive_next;
  logic [15:0] active_next;
  logic [15:0] garbage_next;
  rtua_pkg::link_t link_next;

  logic        match;
  logic [5:0]  metric_sum;

  assign match      = valid && (hop == in_link.hop) && !in_link.hit;
  assign metric_sum = {1'b0, in_link.metric} + {1'b0, metric};

  always_comb begin
    valid_next    = valid;
    hop_next      = hop;
    port_next     = port;
    addr_next     = addr;
    metric_next   = metric;
    inactive_next = inactive;
    active_next   = active_ticks;
    garbage_next  = garbage_ticks;
    link_next     = in_link;
    if (in_valid) begin
      case (in_link.action)
        rtua_pkg::ACT_UPDATE: begin
          if (match) begin
            link_next.hit = 1'b1;
            if (!inactive) begin
              if (metric_sum >= {1'b0, rtua_pkg::METRIC_INF}) begin
                addr_next     = in_link.addr;
                metric_next   = rtua_pkg::METRIC_INF;
                inactive_next = 1'b1;
              end else if (metric > in_link.metric) begin
                addr_next   = in_link.addr;
                metric_next = in_link.metric;
              end
              active_next  = '0;
              garbage_next = '0;
            end else if ((in_link.metric < rtua_pkg::METRIC_INF) &&
                         (metric > in_link.metric)) begin
              addr_next     = in_link.addr;
              metric_next   = in_link.metric;
              inactive_next = 1'b0;
              active_next   = '0;
              garbage_next  = '0;
            end
          end else if (!valid && !in_link.hit) begin
            link_next.hit     = 1'b1;
            link_next.created = 1'b1;
            valid_next        = 1'b1;
            hop_next          = in_link.hop;
            port_next         = in_link.port;
            addr_next         = in_link.addr;
            metric_next       = in_link.metric;
            inactive_next     = 1'b0;
            active_next       = '0;
            garbage_next      = '0;
          end
        end
        rtua_pkg::ACT_TICK: begin
          if (valid) begin
            if (port != '0) begin
              if (!inactive) begin
                if (active_ticks != rtua_pkg::TICK_MAX) begin
                  active_next = active_ticks + 16'd1;
                end
              end else if (garbage_ticks != rtua_pkg::TICK_MAX) begin
                garbage_next = garbage_ticks + 16'd1;
              end
            end
            if (active_next > deactivate_time) begin
              active_next   = '0;
              metric_next   = rtua_pkg::METRIC_INF;
              inactive_next = 1'b1;
            end
          end
        end
        rtua_pkg::ACT_LOOKUP: begin
          if (match) begin
            link_next.hit = 1'b1;
            case (in_link.sel)
              rtua_pkg::SEL_HOP:    link_next.value = hop;
              rtua_pkg::SEL_PORT:   link_next.value = port;
              rtua_pkg::SEL_ADDR:   link_next.value = addr;
              rtua_pkg::SEL_METRIC: link_next.value = {11'd0, metric};
              default:              link_next.value = '0;
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid     <= valid_next;
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    hop           <= hop_next;
    port          <= port_next;
    addr          <= addr_next;
    metric        <= metric_next;
    inactive      <= inactive_next;
    active_ticks  <= active_next;
    garbage_ticks <= garbage_next;
    out_link      <= link_next;
  end

endmodule

`default_nettype wire

/* tb/sv/route_table_update_and_aging_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route table update and aging testbench
// Drives update, tick, lookup and unused commands into the route table under
// several deactivation limits. Every transfer is scored against a behavioral
// copy of the table, and each result is compared field by field, in order.
// ----------------------------------------------------------------------------

module route_table_update_and_aging_tb;

  localparam int unsigned DEPTH      = rtua_pkg::TABLE_DEPTH_DEFAULT;
  localparam int unsigned LATENCY    = DEPTH + 2;
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned PHASE_ITEMS = 135;

  typedef struct {
    bit        found;
    bit [15:0] value;
    bit        full;
    bit [4:0]  count;
  } route_reply_t;

  class route_table_model;
    bit           valid     [DEPTH];
    bit [15:0]    rt_hop    [DEPTH];
    bit [15:0]    rt_port   [DEPTH];
    bit [15:0]    rt_addr   [DEPTH];
    bit [4:0]     rt_metric [DEPTH];
    bit           rt_down   [DEPTH];
    bit [15:0]    age_ticks [DEPTH];
    bit [15:0]    hold_ticks[DEPTH];
    bit [15:0]    deact_limit;
    route_reply_t pending_replies[$];
    int           mismatch_count;
    int           reply_count;

    function new();
      deact_limit = rtua_pkg::DEACTIVATE_RESET;
      foreach (valid[i]) valid[i] = 1'b0;
      mismatch_count = 0;
      reply_count = 0;
    endfunction

    function void set_limit(bit [15:0] lim);
      deact_limit = lim;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function int find_route(bit [15:0] key);
      for (int i = 0; i < DEPTH; i++)
        if (valid[i] && rt_hop[i] == key) return i;
      return -1;
    endfunction

    function bit apply_update(bit [15:0] key, bit [15:0] prt, bit [15:0] adr,
                              bit [4:0] met);
      int idx;
      idx = find_route(key);
      if (idx < 0) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!valid[i]) begin
            valid[i]      = 1'b1;
            rt_hop[i]     = key;
            rt_port[i]    = prt;
            rt_addr[i]    = adr;
            rt_metric[i]  = met;
            rt_down[i]    = 1'b0;
            age_ticks[i]  = '0;
            hold_ticks[i] = '0;
            return 1'b0;
          end
        end
        return 1'b1;
      end
      if (!rt_down[idx]) begin
        if (int'(met) + int'(rt_metric[idx]) >= int'(rtua_pkg::METRIC_INF)) begin
          rt_addr[idx]   = adr;
          rt_metric[idx] = rtua_pkg::METRIC_INF;
          rt_down[idx]   = 1'b1;
        end else if (rt_metric[idx] > met) begin
          rt_addr[idx]   = adr;
          rt_metric[idx] = met;
        end
        age_ticks[idx]  = '0;
        hold_ticks[idx] = '0;
      end else if (met < rtua_pkg::METRIC_INF && rt_metric[idx] > met) begin
        rt_addr[idx]    = adr;
        rt_metric[idx]  = met;
        rt_down[idx]    = 1'b0;
        age_ticks[idx]  = '0;
        hold_ticks[idx] = '0;
      end
      return 1'b0;
    endfunction

    function void age_routes();
      for (int i = 0; i < DEPTH; i++) begin
        if (valid[i]) begin
          if (rt_port[i] != 0) begin
            if (!rt_down[i]) begin
              if (age_ticks[i] != rtua_pkg::TICK_MAX) age_ticks[i]++;
            end else if (hold_ticks[i] != rtua_pkg::TICK_MAX) begin
              hold_ticks[i]++;
            end
          end
          if (age_ticks[i] > deact_limit) begin
            age_ticks[i] = '0;
            rt_metric[i] = rtua_pkg::METRIC_INF;
            rt_down[i]   = 1'b1;
          end
        end
      end
    endfunction

    function void note_command(rtua_pkg::action_t act, bit [15:0] key, bit [15:0] prt,
                               bit [15:0] adr, bit [4:0] met, rtua_pkg::sel_t sel);
      route_reply_t r;
      int           idx;
      int           n;
      r = '{found: 1'b0, value: '0, full: 1'b0, count: '0};
      case (act)
        rtua_pkg::ACT_UPDATE: r.full = apply_update(key, prt, adr, met);
        rtua_pkg::ACT_TICK:   age_routes();
        rtua_pkg::ACT_LOOKUP: begin
          idx = find_route(key);
          if (idx >= 0) begin
            r.found = 1'b1;
            case (sel)
              rtua_pkg::SEL_HOP:    r.value = rt_hop[idx];
              rtua_pkg::SEL_PORT:   r.value = rt_port[idx];
              rtua_pkg::SEL_ADDR:   r.value = rt_addr[idx];
              rtua_pkg::SEL_METRIC: r.value = 16'(rt_metric[idx]);
              default:              r.value = '0;
            endcase
          end
        end
        default: ;
      endcase
      n = 0;
      foreach (valid[i]) if (valid[i]) n++;
      r.count = (n > int'(rtua_pkg::COUNT_MAX)) ? rtua_pkg::COUNT_MAX : 5'(n);
      pending_replies.push_back(r);
    endfunction

    function void report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] result %0d: %s", $realtime, reply_count, what);
    endfunction

    function void check_result(logic fnd, logic [15:0] val, logic ful, logic [4:0] cnt);
      route_reply_t e;
      reply_count++;
      if (pending_replies.size() == 0) begin
        report_mismatch("result with no command outstanding");
        return;
      end
      e = pending_replies.pop_front();
      if (fnd !== e.found || val !== e.value || ful !== e.full || cnt !== e.count)
        report_mismatch($sformatf(
          "exp found=%0b value=%h full=%0b count=%0d, got found=%0b value=%h full=%0b count=%0d",
          e.found, e.value, e.full, e.count, fnd, val, ful, cnt));
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic [1:0]  action       = rtua_pkg::ACT_NONE;
  logic [15:0] hop_id       = '0;
  logic [15:0] out_port     = '0;
  logic [15:0] dest_addr    = '0;
  logic [4:0]  route_metric = '0;
  logic [1:0]  field_select = rtua_pkg::SEL_HOP;
  logic        cfg_we       = 1'b0;
  logic [15:0] cfg_wdata    = '0;
  logic        busy;
  logic        done;
  logic        found;
  logic [15:0] field_value;
  logic        table_full;
  logic [4:0]  entry_count;

  route_table_model model;
  bit               idle_on = 1'b1;
  bit [15:0]        key_pool  [20];
  bit [15:0]        limit_plan[6] = '{16'd0, 16'd65534, 16'd2, 16'd5, 16'd180, 16'd0};
  int unsigned      quiet_cycles = 0;

  route_table_update_and_aging u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .hop_id       (hop_id),
    .out_port     (out_port),
    .dest_addr    (dest_addr),
    .route_metric (route_metric),
    .field_select (field_select),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .found        (found),
    .field_value  (field_value),
    .table_full   (table_full),
    .entry_count  (entry_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        model.note_command(rtua_pkg::action_t'(action), hop_id, out_port, dest_addr,
                           route_metric, rtua_pkg::sel_t'(field_select));
      if (done === 1'b1)
        model.check_result(found, field_value, table_full, entry_count);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_MAX) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(rtua_pkg::action_t act, bit [15:0] key, bit [15:0] prt,
                       bit [15:0] adr, bit [4:0] met, rtua_pkg::sel_t sel);
    int gap;
    if (idle_on && $urandom_range(99) < 21) begin
      start <= 1'b0;
      gap = $urandom_range(1, 30);
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    action       <= act;
    hop_id       <= key;
    out_port     <= prt;
    dest_addr    <= adr;
    route_metric <= met;
    field_select <= sel;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (model.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_limit(bit [15:0] lim);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_limit(lim);
  endtask

  function automatic bit [15:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(19)];
    return 16'($urandom);
  endfunction

  task automatic random_items(int count);
    int                r;
    rtua_pkg::action_t act;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      act = (r < 45) ? rtua_pkg::ACT_UPDATE : (r < 70) ? rtua_pkg::ACT_TICK :
            (r < 97) ? rtua_pkg::ACT_LOOKUP : rtua_pkg::ACT_NONE;
      issue(act, pick_key(),
            ($urandom_range(99) < 15) ? 16'd0 : 16'($urandom),
            16'($urandom),
            ($urandom_range(99) < 85) ? 5'($urandom_range(16)) : 5'($urandom_range(31)),
            rtua_pkg::sel_t'($urandom_range(3)));
    end
  endtask

  initial begin
    model = new();
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h0001;
    limit_plan[5] = 16'($urandom_range(1, 20));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    issue(rtua_pkg::ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, rtua_pkg::SEL_METRIC);
    issue(rtua_pkg::ACT_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_PORT);
    issue(rtua_pkg::ACT_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_ADDR);
    issue(rtua_pkg::ACT_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_METRIC);
    issue(rtua_pkg::ACT_UPDATE, 16'h0001, 16'h0001, 16'h0064, 5'd5, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_UPDATE, 16'h0001, 16'h0002, 16'h00C8, 5'd3, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_ADDR);
    issue(rtua_pkg::ACT_UPDATE, 16'h0001, 16'h0001, 16'h012C, 5'd13, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_METRIC);
    issue(rtua_pkg::ACT_UPDATE, 16'h0001, 16'h0001, 16'h0190, 5'd20, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_UPDATE, 16'h0001, 16'h0001, 16'h01F4, 5'd2, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_ADDR);
    issue(rtua_pkg::ACT_NONE,   16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, rtua_pkg::SEL_METRIC);
    issue(rtua_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_UPDATE, 16'hFFFF, 16'h0000, 16'h1234, 5'd0, rtua_pkg::SEL_HOP);
    issue(rtua_pkg::ACT_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_METRIC);
    issue(rtua_pkg::ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_PORT);
    drain();

    for (int p = 0; p < 6; p++) begin
      idle_on = (p != 2);
      write_limit(limit_plan[p]);
      if (p == 0) begin
        issue(rtua_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_HOP);
        issue(rtua_pkg::ACT_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_METRIC);
        issue(rtua_pkg::ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 5'd0, rtua_pkg::SEL_METRIC);
      end
      random_items(PHASE_ITEMS);
      drain();
    end
    idle_on = 1'b1;

    repeat (LATENCY + 2) @(posedge clk);
    if (model.mismatch_count == 0 && model.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
